/* hdl/chash_pkg.sv */
package chash_pkg;

  localparam int DEF_BUCKETS    = 128;
  localparam int DEF_POOL_NODES = 1024;

  // Bucket hash: (seed * 33 + key) mod BUCKETS, the sum wrapping at 32 bits.
  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int          HASH_SHIFT = 5;
  localparam logic [31:0] HASH_BASE  = (HASH_SEED << HASH_SHIFT) + HASH_SEED;
  localparam int          HASH_W     = 32;

  // The remainder unit retires this many dividend bits per cycle.
  localparam int REM_BITS_PER_CYC = 8;
  localparam int REM_CYCLES       = HASH_W / REM_BITS_PER_CYC;
  localparam int REM_CNT_W        = $clog2(REM_CYCLES);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic               op;
    logic        [31:0] key;
    logic signed [31:0] value_in;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] value_out;
    logic               pool_full;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_WALK,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

/* hdl/chash_rem.sv */
module chash_rem import chash_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [HASH_W-1:0]          sum,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] rem
);

  localparam int BW = $clog2(BUCKETS);
  localparam logic [BW:0] BUCK_C = (BW+1)'(BUCKETS);
  localparam logic [REM_CNT_W-1:0] CNT_LAST = REM_CNT_W'(REM_CYCLES - 1);

  logic [HASH_W-1:0]    sum_r;
  logic [BW-1:0]        rem_r;
  logic [BW-1:0]        rem_nxt;
  logic [REM_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [BW-1:0]        part;
  logic [BW:0]          trial;

  // Restoring remainder: shift in one dividend bit, subtract the divisor
  // once if the partial remainder reached it.
  always_comb begin
    part  = rem_r;
    trial = '0;
    for (int i = 0; i < REM_BITS_PER_CYC; i++) begin
      trial = {part, sum_r[HASH_W-1-i]};
      if (trial >= BUCK_C) begin
        trial = trial - BUCK_C;
      end
      part = trial[BW-1:0];
    end
    rem_nxt = part;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= sum;
      rem_r <= '0;
    end else if (run_r) begin
      sum_r <= sum_r << REM_BITS_PER_CYC;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hdl/chash_mem.sv */
module chash_mem import chash_pkg::*; #(
  parameter int WIDTH = HASH_W,
  parameter int DEPTH = DEF_BUCKETS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/chained_hash_table.sv */
// Separate-chaining hash table over a pool of POOL_NODES nodes with BUCKETS
// chain heads. A request either inserts key/value_in at the head of its
// bucket's chain (newest duplicate wins) or looks key up and returns hit and
// the value. One request is in flight at a time. The bucket index is computed
// by a shared shift-subtract remainder unit, then the bucket head is read
// from a RAM with registered output. A lookup then walks the chain; each
// node visited costs one node RAM read and one key compare, and a lookup
// that matches no node ends on a walk step that finds the end of the chain.
// The next request can be accepted the cycle after the result is loaded.
// A full pool drops the insert and reports pool_full. After reset the block
// clears the bucket head RAM, one entry per cycle, and holds in_ready low
// until every entry is cleared. The next request is accepted while a
// finished result waits in the output register.
module chained_hash_table import chash_pkg::*; #(
  parameter int BUCKETS    = DEF_BUCKETS,
  parameter int POOL_NODES = DEF_POOL_NODES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int BW = $clog2(BUCKETS);
  localparam int IW = $clog2(POOL_NODES);
  localparam int UW = $clog2(POOL_NODES + 1);
  localparam int LW = IW + 1;
  localparam int NW = 2 * HASH_W + LW;
  localparam logic [BW-1:0] CLR_LAST  = BW'(BUCKETS - 1);
  localparam logic [UW-1:0] POOL_SIZE = UW'(POOL_NODES);

  state_t state_r;
  state_t state_nxt;

  logic                      op_r;
  logic [HASH_W-1:0]         key_r;
  logic signed [HASH_W-1:0]  val_r;
  logic [BW-1:0]             bucket_r;
  logic [BW-1:0]             clr_r;
  logic [LW-1:0]             cur_r;
  logic [UW-1:0]             steps_r;
  logic [UW-1:0]             nodes_used_r;
  logic                      res_hit_r;
  logic signed [HASH_W-1:0]  res_val_r;
  logic                      res_full_r;
  logic                      out_valid_r;
  out_t                      out_data_r;

  logic                      in_acc;
  logic                      out_load;
  logic                      pool_is_full;
  logic                      key_match;
  logic                      walk_end;

  logic                      rem_start;
  logic                      rem_done;
  logic [BW-1:0]             rem;

  logic                      head_we;
  logic [BW-1:0]             head_waddr;
  logic [LW-1:0]             head_wdata;
  logic [LW-1:0]             head_rdata;
  logic                      node_we;
  logic [NW-1:0]             node_wdata;
  logic [NW-1:0]             node_rdata;

  chash_rem #(
    .BUCKETS (BUCKETS)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .sum   (HASH_BASE + in_data.key),
    .done  (rem_done),
    .rem   (rem)
  );

  chash_mem #(
    .WIDTH (LW),
    .DEPTH (BUCKETS)
  ) u_head_mem (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (rem),
    .rdata (head_rdata)
  );

  // Node word: key, value, next link (valid bit over index).
  chash_mem #(
    .WIDTH (NW),
    .DEPTH (POOL_NODES)
  ) u_node_mem (
    .clk   (clk),
    .we    (node_we),
    .waddr (nodes_used_r[IW-1:0]),
    .wdata (node_wdata),
    .raddr (cur_r[IW-1:0]),
    .rdata (node_rdata)
  );

  assign in_acc       = in_valid && in_ready;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign pool_is_full = (nodes_used_r == POOL_SIZE);
  assign key_match    = (node_rdata[NW-1 -: HASH_W] == key_r);
  assign walk_end     = !cur_r[LW-1] || (steps_r >= nodes_used_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (rem_done) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        state_nxt = (op_r == OP_LOOKUP) ? ST_WALK : ST_DONE;
      end
      ST_WALK: begin
        state_nxt = walk_end ? ST_DONE : ST_CMP;
      end
      ST_CMP: begin
        state_nxt = key_match ? ST_DONE : ST_WALK;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    rem_start  = 1'b0;
    head_we    = 1'b0;
    head_waddr = bucket_r;
    head_wdata = '0;
    node_we    = 1'b0;
    node_wdata = {key_r, val_r, head_rdata};
    unique case (state_r)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        rem_start = in_valid;
      end
      ST_HEAD: begin
        if (op_r == OP_INSERT && !pool_is_full) begin
          head_we    = 1'b1;
          head_wdata = {1'b1, nodes_used_r[IW-1:0]};
          node_we    = 1'b1;
        end
      end
      ST_HASH, ST_WALK, ST_CMP, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      nodes_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (node_we) begin
        nodes_used_r <= nodes_used_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_data.op;
      key_r <= in_data.key;
      val_r <= in_data.value_in;
    end
    if (state_r == ST_HASH && rem_done) begin
      bucket_r <= rem;
    end
    unique case (state_r)
      ST_HEAD: begin
        cur_r      <= head_rdata;
        steps_r    <= '0;
        res_hit_r  <= 1'b0;
        res_val_r  <= '0;
        res_full_r <= (op_r == OP_INSERT) && pool_is_full;
      end
      ST_CMP: begin
        if (key_match) begin
          res_hit_r <= 1'b1;
          res_val_r <= node_rdata[NW-HASH_W-1 -: HASH_W];
        end else begin
          cur_r   <= node_rdata[LW-1:0];
          steps_r <= steps_r + 1'b1;
        end
      end
      ST_CLEAR, ST_IDLE, ST_HASH, ST_WALK, ST_DONE: begin
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r.hit       <= res_hit_r;
      out_data_r.value_out <= res_val_r;
      out_data_r.pool_full <= res_full_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // A dropped insert is only reported once every pool node is in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pool_full |-> nodes_used_r == POOL_SIZE)
    else $error("pool_full reported with free nodes left");

  // The pool fill count only ever grows by one node at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (nodes_used_r == $past(nodes_used_r)) ||
             (nodes_used_r == $past(nodes_used_r) + 1'b1))
    else $error("node pool count jumped");

  // A new result is only loaded from the finishing state of the sequencer.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result issued outside the finishing state");

  // No insert is taken while the bucket heads are still being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !node_we && !in_ready)
    else $error("request activity during head clearing pass");
`endif

endmodule
